// ===== src/lkv_pkg.sv =====
// Package for the LRU key-value cache: request and response payload types,
// request codes and configuration constants. No dependencies.
`default_nettype none

package lkv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef struct packed {
        logic                    req_type;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic                    found;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/lkv_if.sv =====
// Channel interfaces for the LRU key-value cache: request, response and
// capacity write. Depends on lkv_pkg.
`default_nettype none

interface lkv_req_if;
    import lkv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;

    modport source (output valid, output found, output read_value, output evicted,
                    output evicted_key, input ready);
    modport sink   (input valid, input found, input read_value, input evicted,
                    input evicted_key, output ready);
endinterface

interface lkv_cfg_if;
    import lkv_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
// A request beat is captured in lkv_req_reg, and its response is registered in lkv_rsp_reg once that register is free.
// Throughput: one request per cycle while the response sink is ready, set by the combinational parallel key match
// and rank update over all entries in the store.
// Reset: clears every entry's valid bit and the occupancy; capacity returns to 16.
// Top level of the LRU key-value cache; depends on lkv_pkg, lkv_if and the
// lkv_req_reg, lkv_store and lkv_rsp_reg modules.
`default_nettype none

module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    lkv_req_if.sink   req,
    lkv_rsp_if.source rsp,
    lkv_cfg_if.sink   cfg
);

    logic [CAP_W-1:0] cap_reg;
    logic             pending;
    logic             free;
    logic             fire;
    req_t             item;
    rsp_t             result;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            cap_reg <= cfg.capacity;
        end
    end

    assign fire = pending && free;

    lkv_req_reg u_req_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .take    (fire),
        .pending (pending),
        .item    (item)
    );

    lkv_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (item),
        .capacity (cap_reg),
        .result   (result)
    );

    lkv_rsp_reg u_rsp_reg (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .data  (result),
        .free  (free),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

// ===== src/lkv_req_reg.sv =====
// Input register of the LRU key-value cache: holds one request beat until
// the lookup stage takes it. Depends on lkv_pkg and lkv_req_if.
`default_nettype none

module lkv_req_reg
    import lkv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lkv_req_if.sink    req,
    input  wire logic  take,
    output logic       pending,
    output req_t       item
);

    logic pend_reg;
    logic pend_next;
    req_t item_reg;
    logic accept;

    assign req.ready = !pend_reg || take;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (take)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{req_type: req.req_type, key: req.key, value: req.value};
        end
    end

    assign pending = pend_reg;
    assign item    = item_reg;

endmodule

`default_nettype wire

// ===== src/lkv_store.sv =====
// Entry store of the LRU key-value cache: parallel key match, recency ranks,
// victim and free-slot selection, and the state update. Depends on lkv_pkg.
`default_nettype none

module lkv_store
    import lkv_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  wire req_t             item,
    input  wire logic [CAP_W-1:0] capacity,
    output rsp_t                  result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CAP_W) ? OW : CAP_W;

    logic signed [KEY_W-1:0] key_reg   [ENTRIES];
    logic signed [KEY_W-1:0] key_next  [ENTRIES];
    logic signed [VAL_W-1:0] val_reg   [ENTRIES];
    logic signed [VAL_W-1:0] val_next  [ENTRIES];
    logic [IW-1:0]           rank_reg  [ENTRIES];
    logic [IW-1:0]           rank_next [ENTRIES];
    logic [ENTRIES-1:0]      valid_reg;
    logic [ENTRIES-1:0]      valid_next;
    logic [OW-1:0]           occ_reg;
    logic [OW-1:0]           occ_next;

    logic [ENTRIES-1:0]      hit_vec;
    logic [ENTRIES-1:0]      evict_vec;
    logic [ENTRIES-1:0]      free_oh;
    logic [ENTRIES-1:0]      ins_oh;
    logic                    hit;
    logic                    is_put;
    logic                    full;
    logic                    do_evict;
    logic                    do_insert;
    logic [CW-1:0]           cap_eff;
    logic [OW-1:0]           occ_m1;
    logic [IW-1:0]           last_rank;
    logic [IW-1:0]           hit_rank;
    logic signed [VAL_W-1:0] hit_val;
    logic signed [KEY_W-1:0] evict_key;

    assign is_put = (item.req_type == REQ_PUT);

    always_comb
    begin
        cap_eff = CW'(capacity);
        if (capacity == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(capacity) > CW'(ENTRIES))
        begin
            cap_eff = CW'(ENTRIES);
        end
    end

    assign occ_m1    = occ_reg - OW'(1);
    assign last_rank = IW'(occ_m1);
    assign full      = (CW'(occ_reg) >= cap_eff);
    assign free_oh   = ~valid_reg & (valid_reg + ENTRIES'(1));

    always_comb
    begin
        hit_rank  = '0;
        hit_val   = '0;
        evict_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]   = valid_reg[i] && (key_reg[i] == item.key);
            evict_vec[i] = valid_reg[i] && (rank_reg[i] == last_rank);
            hit_rank     = hit_rank | (rank_reg[i] & {IW{hit_vec[i]}});
            hit_val      = hit_val | (val_reg[i] & {VAL_W{hit_vec[i]}});
            evict_key    = evict_key | (key_reg[i] & {KEY_W{evict_vec[i]}});
        end
    end

    assign hit       = |hit_vec;
    assign do_insert = is_put && !hit;
    assign do_evict  = do_insert && full;
    assign ins_oh    = do_evict ? evict_vec : free_oh;

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_next[i]  = key_reg[i];
            val_next[i]  = val_reg[i];
            rank_next[i] = rank_reg[i];
        end
        if (fire && hit)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (hit_vec[i])
                begin
                    rank_next[i] = '0;
                    if (is_put)
                    begin
                        val_next[i] = item.value;
                    end
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
        end
        else if (fire && do_insert)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (ins_oh[i])
                begin
                    key_next[i]   = item.key;
                    val_next[i]   = item.value;
                    rank_next[i]  = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i])
                begin
                    rank_next[i] = rank_reg[i] + IW'(1);
                end
            end
            if (!do_evict)
            begin
                occ_next = occ_reg + OW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_reg[i]  <= key_next[i];
            val_reg[i]  <= val_next[i];
            rank_reg[i] <= rank_next[i];
        end
    end

    always_comb
    begin
        result.found       = hit;
        result.read_value  = (hit && !is_put) ? hit_val : '0;
        result.evicted     = do_evict;
        result.evicted_key = do_evict ? evict_key : '0;
    end

endmodule

`default_nettype wire

// ===== src/lkv_rsp_reg.sv =====
// Result register of the LRU key-value cache: holds one response beat until
// the sink takes it. Depends on lkv_pkg and lkv_rsp_if.
`default_nettype none

module lkv_rsp_reg
    import lkv_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire rsp_t  data,
    output logic       free,
    lkv_rsp_if.source  rsp
);

    logic valid_reg;
    logic valid_next;
    rsp_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.found       = data_reg.found;
    assign rsp.read_value  = data_reg.read_value;
    assign rsp.evicted     = data_reg.evicted;
    assign rsp.evicted_key = data_reg.evicted_key;

endmodule

`default_nettype wire

// ===== src/lkv_chk.sv =====
// Port-level checker for the LRU key-value cache and its bind to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
`default_nettype none

module lkv_chk
    import lkv_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    rsp_valid,
    input wire logic                    rsp_ready,
    input wire logic                    found,
    input wire logic signed [VAL_W-1:0] read_value,
    input wire logic                    evicted,
    input wire logic signed [KEY_W-1:0] evicted_key
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && evicted |-> !found)
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !evicted |-> evicted_key == '0)
        else $error("evicted key nonzero without eviction");

    a_read_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_value != '0) |-> found)
        else $error("read value nonzero on a miss");

endmodule

bind lru_key_value_cache lkv_chk u_lkv_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .found       (rsp.found),
    .read_value  (rsp.read_value),
    .evicted     (rsp.evicted),
    .evicted_key (rsp.evicted_key)
);

`default_nettype wire
